// File: hdl/tlpq_pkg.sv
// types and constants shared by the three-level ticket priority queue
// item structs for both channels, status, mode and level codes
// no dependencies
package tlpq_pkg;

  localparam int TKT_W   = 16;
  localparam int COUNT_W = 5;

  localparam logic       MODE_INSERT = 1'b0;
  localparam logic       MODE_REMOVE = 1'b1;

  localparam logic [1:0] LVL_NONE   = 2'd0;
  localparam logic [1:0] LVL_RED    = 2'd1;
  localparam logic [1:0] LVL_YELLOW = 2'd2;
  localparam logic [1:0] LVL_GREEN  = 2'd3;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_BAD_LEVEL = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;
  localparam logic [1:0] ST_NOT_FOUND = 2'd3;

  typedef struct packed {
    logic             mode;
    logic [1:0]       level;
    logic [TKT_W-1:0] ticket_to_remove;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [TKT_W-1:0]   assigned_ticket;
    logic [COUNT_W-1:0] red_count;
    logic [COUNT_W-1:0] yellow_count;
    logic [COUNT_W-1:0] green_count;
  } out_item_t;

endpackage

// File: hdl/three_level_ticket_priority_queue.sv
// three-level ticket priority queue: sorted entry table in a memory, one sequencer
// walks the table one entry per cycle for insert and remove
// depends on tlpq_pkg
//
//   channel | ports                           | item
//   --------+---------------------------------+-----------------------
//   input   | in_valid, in_stall, in_item     | tlpq_pkg::in_item_t
//   output  | out_valid, out_stall, out_item  | tlpq_pkg::out_item_t
//
// insert walks back from the table end over the entries ranked after the new one;
// remove walks every table entry; refused items go straight to the final state.
// the single memory read port, one entry per cycle, bounds both walks.
// reset clears counts and sets the ticket counter to 1; the table needs no clearing.
// a new item is taken while a result waits; a stalled result holds the next one
// in its final state until the output register frees.
module three_level_ticket_priority_queue #(
  parameter int DEPTH       = 16,
  parameter int TICKET_BITS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  tlpq_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output tlpq_pkg::out_item_t out_item
);
  import tlpq_pkg::*;

  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int CMP_W = (TICKET_BITS > TKT_W) ? TICKET_BITS : TKT_W;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_INS  = 3'd1;
  localparam logic [2:0] S_REM  = 3'd2;
  localparam logic [2:0] S_FIN  = 3'd3;

  typedef struct packed {
    logic [TICKET_BITS-1:0] ticket;
    logic [1:0]             level;
  } entry_t;

  entry_t                 mem_r [DEPTH];
  entry_t                 rd_data_r;
  logic [IDX_W-1:0]       rd_addr;
  logic                   wr_en;
  logic [IDX_W-1:0]       wr_addr;
  entry_t                 wr_data;

  logic [2:0]             state_r, state_nxt;
  logic [CNT_W-1:0]       used_r, used_nxt;
  logic [IDX_W-1:0]       ptr_r, ptr_nxt;
  logic                   found_r, found_nxt;
  logic [1:0]             op_lvl_r, op_lvl_nxt;
  logic [TKT_W-1:0]       op_tkt_r, op_tkt_nxt;
  logic [1:0]             status_r, status_nxt;
  logic [TKT_W-1:0]       given_r, given_nxt;
  logic [TICKET_BITS-1:0] next_tkt_r, next_tkt_nxt, tkt_inc;
  logic [COUNT_W-1:0]     red_r, red_nxt, yel_r, yel_nxt, grn_r, grn_nxt;
  logic                   out_valid_r, out_valid_nxt;
  out_item_t              out_item_r, out_item_nxt;
  logic                   hit;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign tkt_inc = next_tkt_r + TICKET_BITS'(1);
  assign hit = !found_r && (CMP_W'(rd_data_r.ticket) == CMP_W'(op_tkt_r));

  always_comb begin
    state_nxt     = state_r;
    used_nxt      = used_r;
    ptr_nxt       = ptr_r;
    found_nxt     = found_r;
    op_lvl_nxt    = op_lvl_r;
    op_tkt_nxt    = op_tkt_r;
    status_nxt    = status_r;
    given_nxt     = given_r;
    next_tkt_nxt  = next_tkt_r;
    red_nxt       = red_r;
    yel_nxt       = yel_r;
    grn_nxt       = grn_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_item_nxt  = out_item_r;
    rd_addr       = '0;
    wr_en         = 1'b0;
    wr_addr       = ptr_r;
    wr_data       = rd_data_r;

    unique case (state_r)
      S_IDLE: begin
        rd_addr = (in_item.mode == MODE_INSERT) ? IDX_W'(used_r - CNT_W'(1)) : '0;
        if (in_valid) begin
          op_lvl_nxt = in_item.level;
          op_tkt_nxt = in_item.ticket_to_remove;
          given_nxt  = '0;
          found_nxt  = 1'b0;
          ptr_nxt    = '0;
          if (in_item.mode == MODE_INSERT) begin
            if (in_item.level == LVL_NONE) begin
              status_nxt = ST_BAD_LEVEL;
              state_nxt  = S_FIN;
            end else if (used_r == CNT_W'(DEPTH)) begin
              status_nxt = ST_FULL;
              state_nxt  = S_FIN;
            end else begin
              ptr_nxt   = IDX_W'(used_r);
              state_nxt = S_INS;
            end
          end else begin
            if (used_r == '0) begin
              status_nxt = ST_NOT_FOUND;
              state_nxt  = S_FIN;
            end else begin
              state_nxt = S_REM;
            end
          end
        end
      end
      S_INS: begin
        rd_addr = ptr_r - IDX_W'(2);
        wr_en   = 1'b1;
        wr_addr = ptr_r;
        if (ptr_r == '0 || rd_data_r.level <= op_lvl_r) begin
          // slot found: drop the new entry here
          wr_data.ticket = next_tkt_r;
          wr_data.level  = op_lvl_r;
          used_nxt       = used_r + CNT_W'(1);
          given_nxt      = TKT_W'(next_tkt_r);
          next_tkt_nxt   = (tkt_inc == '0) ? TICKET_BITS'(1) : tkt_inc;
          status_nxt     = ST_OK;
          state_nxt      = S_FIN;
          unique case (op_lvl_r)
            LVL_RED:    red_nxt = red_r + COUNT_W'(1);
            LVL_YELLOW: yel_nxt = yel_r + COUNT_W'(1);
            LVL_GREEN:  grn_nxt = grn_r + COUNT_W'(1);
            default: ;
          endcase
        end else begin
          ptr_nxt = ptr_r - IDX_W'(1);
        end
      end
      S_REM: begin
        rd_addr = ptr_r + IDX_W'(1);
        wr_en   = found_r;
        wr_addr = ptr_r - IDX_W'(1);
        if (hit) begin
          found_nxt = 1'b1;
          unique case (rd_data_r.level)
            LVL_RED:    red_nxt = red_r - COUNT_W'(1);
            LVL_YELLOW: yel_nxt = yel_r - COUNT_W'(1);
            LVL_GREEN:  grn_nxt = grn_r - COUNT_W'(1);
            default: ;
          endcase
        end
        if (CNT_W'(ptr_r) == used_r - CNT_W'(1)) begin
          if (found_r || hit) begin
            used_nxt   = used_r - CNT_W'(1);
            status_nxt = ST_OK;
          end else begin
            status_nxt = ST_NOT_FOUND;
          end
          state_nxt = S_FIN;
        end else begin
          ptr_nxt = ptr_r + IDX_W'(1);
        end
      end
      S_FIN: begin
        if (!out_valid_r || !out_stall) begin
          out_item_nxt.status          = status_r;
          out_item_nxt.assigned_ticket = given_r;
          out_item_nxt.red_count       = red_r;
          out_item_nxt.yellow_count    = yel_r;
          out_item_nxt.green_count     = grn_r;
          out_valid_nxt                = 1'b1;
          state_nxt                    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      used_r      <= '0;
      found_r     <= 1'b0;
      next_tkt_r  <= TICKET_BITS'(1);
      red_r       <= '0;
      yel_r       <= '0;
      grn_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      used_r      <= used_nxt;
      found_r     <= found_nxt;
      next_tkt_r  <= next_tkt_nxt;
      red_r       <= red_nxt;
      yel_r       <= yel_nxt;
      grn_r       <= grn_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ptr_r      <= ptr_nxt;
    op_lvl_r   <= op_lvl_nxt;
    op_tkt_r   <= op_tkt_nxt;
    status_r   <= status_nxt;
    given_r    <= given_nxt;
    out_item_r <= out_item_nxt;
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= CNT_W'(DEPTH))
    else $error("entry count above table depth");

  a_count_sum: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_IDLE |-> COUNT_W'(red_r + yel_r + grn_r) == COUNT_W'(used_r))
    else $error("level counts disagree with entry count");

  a_ticket_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    next_tkt_r != '0)
    else $error("next ticket is zero");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> state_r != S_IDLE)
    else $error("sequencer idle after taking an item");

endmodule

// File: tb/tb_three_level_ticket_priority_queue.sv
// testbench for the three-level ticket priority queue: directed and random items,
// a model of the ordered entry table predicts each result, checked field by field
// depends on tlpq_pkg and three_level_ticket_priority_queue
module tb_three_level_ticket_priority_queue;
  import tlpq_pkg::*;

  localparam int QUEUE_DEPTH = 16;

  logic      clk;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_item = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_item;

  logic [TKT_W-1:0] queue_ticket [QUEUE_DEPTH];
  logic [1:0]       queue_level [QUEUE_DEPTH];
  int               queue_used = 0;
  logic [TKT_W-1:0] next_ticket_no = TKT_W'(1);

  out_item_t   pending_results [$];
  int unsigned error_count = 0;
  int unsigned stall_burst = 0;
  bit          tx_gaps_on = 1'b0;
  bit          rx_gaps_on = 1'b0;

  three_level_ticket_priority_queue #(
    .DEPTH      (QUEUE_DEPTH),
    .TICKET_BITS(TKT_W)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item (out_item)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic out_item_t apply_to_queue(in_item_t it);
    out_item_t   res;
    int          pos;
    int          i;
    int unsigned per_level [4];
    res = '0;
    per_level = '{0, 0, 0, 0};
    if (it.mode == MODE_INSERT) begin
      if (it.level == LVL_NONE) begin
        res.status = ST_BAD_LEVEL;
      end else if (queue_used >= QUEUE_DEPTH) begin
        res.status = ST_FULL;
      end else begin
        pos = 0;
        while (pos < queue_used && queue_level[pos] <= it.level) pos++;
        for (i = queue_used; i > pos; i--) begin
          queue_ticket[i] = queue_ticket[i-1];
          queue_level[i] = queue_level[i-1];
        end
        queue_ticket[pos] = next_ticket_no;
        queue_level[pos] = it.level;
        queue_used++;
        res.status = ST_OK;
        res.assigned_ticket = next_ticket_no;
        next_ticket_no = next_ticket_no + 1'b1;
        if (next_ticket_no == '0) next_ticket_no = TKT_W'(1);
      end
    end else begin
      pos = 0;
      while (pos < queue_used && queue_ticket[pos] != it.ticket_to_remove) pos++;
      if (pos >= queue_used) begin
        res.status = ST_NOT_FOUND;
      end else begin
        for (i = pos; i + 1 < queue_used; i++) begin
          queue_ticket[i] = queue_ticket[i+1];
          queue_level[i] = queue_level[i+1];
        end
        queue_used--;
        res.status = ST_OK;
      end
    end
    for (i = 0; i < queue_used; i++) per_level[queue_level[i]]++;
    res.red_count = COUNT_W'(per_level[LVL_RED]);
    res.yellow_count = COUNT_W'(per_level[LVL_YELLOW]);
    res.green_count = COUNT_W'(per_level[LVL_GREEN]);
    return res;
  endfunction

  task automatic report_mismatch(string what);
    if (error_count < 40) $display("[%0t] mismatch: %s", $time, what);
    error_count++;
  endtask

  task automatic check_field(string name, logic [TKT_W-1:0] got, logic [TKT_W-1:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
  endtask

  task automatic send_item(in_item_t it);
    int unsigned gap;
    gap = tx_gaps_on ? $urandom_range(0, 18) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_results.push_back(apply_to_queue(it));
  endtask

  task automatic send_insert(logic [1:0] lvl, logic [TKT_W-1:0] ignored_tkt);
    in_item_t it;
    it.mode = MODE_INSERT;
    it.level = lvl;
    it.ticket_to_remove = ignored_tkt;
    send_item(it);
  endtask

  task automatic send_remove(logic [TKT_W-1:0] tkt, logic [1:0] ignored_lvl);
    in_item_t it;
    it.mode = MODE_REMOVE;
    it.level = ignored_lvl;
    it.ticket_to_remove = tkt;
    send_item(it);
  endtask

  task automatic test_basic_ops();
    send_remove('0, LVL_GREEN);
    send_remove('1, LVL_NONE);
    send_insert(LVL_NONE, '1);
    send_insert(LVL_GREEN, '1);
    send_insert(LVL_YELLOW, '0);
    send_insert(LVL_RED, 16'h5a5a);
    send_insert(LVL_GREEN, '0);
    send_insert(LVL_RED, '0);
    send_insert(LVL_YELLOW, '0);
    send_remove(queue_ticket[1], LVL_YELLOW);
    send_remove(TKT_W'(5), LVL_RED);
    send_remove('0, LVL_NONE);
    send_insert(LVL_NONE, '0);
    send_insert(LVL_RED, '1);
  endtask

  task automatic test_full_table();
    while (queue_used < QUEUE_DEPTH) send_insert(2'($urandom_range(1, 3)), 16'($urandom));
    send_insert(LVL_GREEN, '0);
    send_insert(LVL_RED, '1);
    send_insert(LVL_YELLOW, '0);
    send_insert(LVL_NONE, '0);
  endtask

  task automatic test_random_traffic(int unsigned n_items);
    int unsigned k;
    int unsigned insert_pct;
    insert_pct = 50;
    for (k = 0; k < n_items; k++) begin
      if (k % 100 == 0) begin
        case ($urandom_range(0, 3))
          0: insert_pct = 25;
          1: insert_pct = 50;
          2: insert_pct = 75;
          default: insert_pct = 95;
        endcase
        tx_gaps_on = ($urandom_range(0, 3) != 0);
        rx_gaps_on = ($urandom_range(0, 3) != 0);
      end
      if ($urandom_range(0, 99) < insert_pct) begin
        if ($urandom_range(0, 9) == 0) send_insert(LVL_NONE, 16'($urandom));
        else send_insert(2'($urandom_range(1, 3)), 16'($urandom));
      end else if (queue_used != 0 && $urandom_range(0, 3) != 0) begin
        send_remove(queue_ticket[$urandom_range(0, queue_used - 1)], 2'($urandom));
      end else begin
        send_remove(16'($urandom), 2'($urandom));
      end
    end
  endtask

  // receiver holds off long enough that the block fills and stalls its input
  task automatic test_output_hold_off();
    int unsigned k;
    tx_gaps_on = 1'b0;
    rx_gaps_on = 1'b1;
    stall_burst = 300;
    for (k = 0; k < 40; k++) begin
      if (k % 3 == 2 && queue_used != 0) send_remove(queue_ticket[0], 2'($urandom));
      else send_insert(2'($urandom_range(1, 3)), 16'($urandom));
    end
  endtask

  initial begin : rx_stall_proc
    int unsigned hold;
    wait (rst_n === 1'b1);
    forever begin
      if (stall_burst != 0) begin
        hold = stall_burst;
        stall_burst = 0;
      end else begin
        hold = rx_gaps_on ? $urandom_range(0, 18) : 0;
      end
      if (hold != 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  always @(posedge clk) begin : check_results
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result arrived with nothing expected");
      end else begin
        want = pending_results.pop_front();
        check_field("status", TKT_W'(out_item.status), TKT_W'(want.status));
        check_field("assigned_ticket", out_item.assigned_ticket, want.assigned_ticket);
        check_field("red_count", TKT_W'(out_item.red_count), TKT_W'(want.red_count));
        check_field("yellow_count", TKT_W'(out_item.yellow_count),
                    TKT_W'(want.yellow_count));
        check_field("green_count", TKT_W'(out_item.green_count),
                    TKT_W'(want.green_count));
      end
    end
  end

  initial begin : watchdog
    #40000000;
    $display("tb_three_level_ticket_priority_queue: FAIL");
    $finish;
  end

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    test_basic_ops();
    test_full_table();
    test_random_traffic(1600);
    test_output_hold_off();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (error_count == 0) $display("tb_three_level_ticket_priority_queue: PASS");
    else $display("tb_three_level_ticket_priority_queue: FAIL");
    $finish;
  end

endmodule
